@@ hdl/pawsp_pkg.sv @@
package pawsp_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_PAGE_SIZE      = 3'd0;
    localparam logic [2:0] CFG_DEVICE_SIZE    = 3'd1;
    localparam logic [2:0] CFG_BURST_LIMIT    = 3'd2;
    localparam logic [2:0] CFG_TWO_BYTE_ADDR  = 3'd3;
    localparam logic [2:0] CFG_BUS_BASE_ADDR  = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 17;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ID_PAGE  = 2'd1;
    localparam logic [1:0] ST_DEVICE   = 2'd2;
    localparam logic [1:0] ST_LENGTH   = 2'd3;

    // identification page sits this far above the main memory bus address
    localparam logic [6:0] ID_PAGE_BUS_OFFSET = 7'd8;

    localparam int ADDR_W  = 16;
    localparam int LEN_W   = 10;
    localparam int CNT_W   = 8;
    localparam int DEV_W   = 17;
    localparam int BUS_W   = 7;
    localparam int BURST_N_W = 6;   // at most 64 descriptors per request

    // effective (legalized) configuration
    typedef struct packed {
        logic [CNT_W-1:0] page;
        logic [DEV_W-1:0] device;
        logic [CNT_W-1:0] limit;
        logic             two_byte;
        logic [BUS_W-1:0] bus_base;
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0]  cnt;
        logic [ADDR_W-1:0] next_addr;
        logic [LEN_W-1:0]  next_len;
    } t_burst;

endpackage

@@ hdl/pawsp_cfg.sv @@
module pawsp_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [pawsp_pkg::CFG_INDEX_W-1:0] i_wr_index,
    input  logic [pawsp_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output pawsp_pkg::t_cfg                   o_cfg
);

    logic [7:0]  r_page_size;
    logic [16:0] r_device_size;
    logic [7:0]  r_burst_limit;
    logic        r_two_byte;
    logic [6:0]  r_bus_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size   <= 8'd64;
            r_device_size <= 17'd32768;
            r_burst_limit <= 8'd30;
            r_two_byte    <= 1'b1;
            r_bus_base    <= 7'd80;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                pawsp_pkg::CFG_PAGE_SIZE:     r_page_size   <= i_wr_data[7:0];
                pawsp_pkg::CFG_DEVICE_SIZE:   r_device_size <= i_wr_data[16:0];
                pawsp_pkg::CFG_BURST_LIMIT:   r_burst_limit <= i_wr_data[7:0];
                pawsp_pkg::CFG_TWO_BYTE_ADDR: r_two_byte    <= i_wr_data[0];
                pawsp_pkg::CFG_BUS_BASE_ADDR: r_bus_base    <= i_wr_data[6:0];
                default: ;
            endcase
        end
    end

    logic [16:0] n_device;

    // largest power of two that fits in the written size, but never below 128
    always_comb begin
        n_device = 17'd128;
        for (int i = 7; i < 17; i++) begin
            if (r_device_size[i]) n_device = 17'(1) << i;
        end
    end

    always_comb begin
        if (r_page_size[7])      o_cfg.page = 8'd128;
        else if (r_page_size[6]) o_cfg.page = 8'd64;
        else if (r_page_size[5]) o_cfg.page = 8'd32;
        else                     o_cfg.page = 8'd16;

        if (r_burst_limit < 8'd16)       o_cfg.limit = 8'd16;
        else if (r_burst_limit > 8'd128) o_cfg.limit = 8'd128;
        else                             o_cfg.limit = r_burst_limit;

        o_cfg.device   = n_device;
        o_cfg.two_byte = r_two_byte;
        o_cfg.bus_base = r_bus_base;
    end

endmodule

@@ hdl/pawsp_burst_unit.sv @@
module pawsp_burst_unit (
    input  logic [pawsp_pkg::ADDR_W-1:0] i_addr,
    input  logic [pawsp_pkg::LEN_W-1:0]  i_len,
    input  logic [pawsp_pkg::CNT_W-1:0]  i_page,
    input  logic [pawsp_pkg::CNT_W-1:0]  i_limit,
    output pawsp_pkg::t_burst            o_burst
);

    logic [7:0] to_edge;
    logic [7:0] lim_edge;
    logic [7:0] cnt;

    always_comb begin
        // bytes left before the page boundary, 1..page
        to_edge  = i_page - (i_addr[7:0] & (i_page - 8'd1));
        lim_edge = (i_limit < to_edge) ? i_limit : to_edge;
        cnt      = (i_len < {2'b00, lim_edge}) ? i_len[7:0] : lim_edge;

        o_burst.cnt       = cnt;
        o_burst.next_addr = i_addr + {8'd0, cnt};
        o_burst.next_len  = i_len - {2'b00, cnt};
    end

endmodule

@@ hdl/page_aligned_write_splitter.sv @@
// Request accepted while idle; the check state does the range/length check, then
// one burst descriptor per cycle, while the output is not stalled, from the
// burst-size unit. An error or empty request gives one result, registered from the
// check state; data bursts are registered from the burst state that follows it.
// No new request is taken until the last result of a request is loaded.
// i_rst_n (synchronous, active low) resets the sequencer, output valid and config.
module page_aligned_write_splitter #(
    parameter int unsigned MAX_REQUEST_BYTES = 1008
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_start_address,
    input  logic [9:0]  i_byte_length,
    input  logic        i_to_id_page,

    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_burst_address,
    output logic [7:0]  o_burst_count,
    output logic [6:0]  o_bus_address,
    output logic [7:0]  o_address_high_byte,
    output logic [7:0]  o_address_low_byte,
    output logic        o_send_high_byte,
    output logic [1:0]  o_status,
    output logic        o_last_burst
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CHECK = 2'd1;
    localparam logic [1:0] S_BURST = 2'd2;

    pawsp_pkg::t_cfg   cfg;
    pawsp_pkg::t_burst burst;

    pawsp_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    logic [1:0]  r_state;
    logic [15:0] r_addr;
    logic [9:0]  r_len;
    logic        r_idp;
    logic [5:0]  r_n;

    pawsp_burst_unit u_burst (
        .i_addr  (r_addr),
        .i_len   (r_len),
        .i_page  (cfg.page),
        .i_limit (cfg.limit),
        .o_burst (burst)
    );

    logic        r_out_valid;
    logic [15:0] r_burst_address;
    logic [7:0]  r_burst_count;
    logic [6:0]  r_bus_address;
    logic [7:0]  r_addr_hi;
    logic [7:0]  r_addr_lo;
    logic        r_send_hi;
    logic [1:0]  r_status;
    logic        r_last;

    logic        slot_free;
    logic        in_xfer;
    logic        out_load;
    logic [16:0] end_addr;
    logic [1:0]  chk_status;
    logic [6:0]  bus_id;
    logic [6:0]  bus_hdr;
    logic        burst_last;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    // a result is loaded into the output register this cycle
    assign out_load    = slot_free && ((r_state == S_BURST) ||
                         (r_state == S_CHECK &&
                          (chk_status != pawsp_pkg::ST_OK || r_len == 10'd0)));

    always_comb begin
        end_addr = {1'b0, r_addr} + {7'd0, r_len};
        if (r_idp && (end_addr > {9'd0, cfg.page}))  chk_status = pawsp_pkg::ST_ID_PAGE;
        else if (end_addr > cfg.device)              chk_status = pawsp_pkg::ST_DEVICE;
        else if (r_len > 10'(MAX_REQUEST_BYTES))     chk_status = pawsp_pkg::ST_LENGTH;
        else                                         chk_status = pawsp_pkg::ST_OK;

        bus_id  = cfg.bus_base + (r_idp ? pawsp_pkg::ID_PAGE_BUS_OFFSET : 7'd0);
        // one-byte addressing folds address bits 10..8 into the bus address
        bus_hdr = cfg.two_byte ? bus_id : (bus_id | {4'd0, r_addr[10:8]});
        burst_last = (burst.next_len == 10'd0) || (&r_n);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (chk_status != pawsp_pkg::ST_OK || r_len == 10'd0) begin
                        if (slot_free) r_state <= S_IDLE;
                    end else begin
                        r_state <= S_BURST;
                    end
                end
                S_BURST: begin
                    if (slot_free && burst_last) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath and output payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_addr <= i_start_address;
            r_len  <= i_byte_length;
            r_idp  <= i_to_id_page;
            r_n    <= 6'd0;
        end
        if (r_state == S_CHECK && slot_free) begin
            r_burst_address <= r_addr;
            r_burst_count   <= 8'd0;
            r_status        <= chk_status;
            r_last          <= 1'b1;
            if (chk_status != pawsp_pkg::ST_OK) begin
                r_bus_address <= 7'd0;
                r_addr_hi     <= 8'd0;
                r_addr_lo     <= 8'd0;
                r_send_hi     <= 1'b0;
            end else begin
                r_bus_address <= bus_hdr;
                r_addr_hi     <= r_addr[15:8];
                r_addr_lo     <= r_addr[7:0];
                r_send_hi     <= cfg.two_byte;
            end
        end
        if (r_state == S_BURST && slot_free) begin
            r_burst_address <= r_addr;
            r_burst_count   <= burst.cnt;
            r_bus_address   <= bus_hdr;
            r_addr_hi       <= r_addr[15:8];
            r_addr_lo       <= r_addr[7:0];
            r_send_hi       <= cfg.two_byte;
            r_status        <= pawsp_pkg::ST_OK;
            r_last          <= burst_last;
            r_addr          <= burst.next_addr;
            r_len           <= burst.next_len;
            r_n             <= r_n + 6'd1;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_burst_address     = r_burst_address;
    assign o_burst_count       = r_burst_count;
    assign o_bus_address       = r_bus_address;
    assign o_address_high_byte = r_addr_hi;
    assign o_address_low_byte  = r_addr_lo;
    assign o_send_high_byte    = r_send_hi;
    assign o_status            = r_status;
    assign o_last_burst        = r_last;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int REQ_BYTES_MAX = 1008;
    localparam int BURSTS_MAX    = 64;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [15:0] i_start_address = '0;
    logic [9:0]  i_byte_length = '0;
    logic        i_to_id_page = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [15:0] o_burst_address;
    logic [7:0]  o_burst_count;
    logic [6:0]  o_bus_address;
    logic [7:0]  o_address_high_byte;
    logic [7:0]  o_address_low_byte;
    logic        o_send_high_byte;
    logic [1:0]  o_status;
    logic        o_last_burst;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  cnt;
        logic [6:0]  bus;
        logic [7:0]  hi;
        logic [7:0]  lo;
        logic        send_hi;
        logic [1:0]  status;
        logic        last;
    } t_burst_desc;

    t_burst_desc pending_bursts[$];
    int          mismatches = 0;
    int          stall_left = 0;
    bit          steady = 1'b0;

    // shadow of the register file, reset values
    logic [7:0]  cfg_page = 8'd64;
    logic [16:0] cfg_device = 17'd32768;
    logic [7:0]  cfg_limit = 8'd30;
    logic        cfg_two_byte = 1'b1;
    logic [6:0]  cfg_bus_base = 7'd80;

    page_aligned_write_splitter dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_start_address     (i_start_address),
        .i_byte_length       (i_byte_length),
        .i_to_id_page        (i_to_id_page),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_burst_address     (o_burst_address),
        .o_burst_count       (o_burst_count),
        .o_bus_address       (o_bus_address),
        .o_address_high_byte (o_address_high_byte),
        .o_address_low_byte  (o_address_low_byte),
        .o_send_high_byte    (o_send_high_byte),
        .o_status            (o_status),
        .o_last_burst        (o_last_burst)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // odd register values snap to the legal setting below, or the smallest if none
    function automatic int unsigned legal_page();
        if (cfg_page >= 8'd128) return 128;
        if (cfg_page >= 8'd64) return 64;
        if (cfg_page >= 8'd32) return 32;
        return 16;
    endfunction

    function automatic int unsigned legal_device();
        int unsigned s;
        s = 128;
        while (s < 65536 && s * 2 <= 32'(cfg_device))
            s = s * 2;
        return s;
    endfunction

    function automatic int unsigned legal_limit();
        if (cfg_limit < 8'd16) return 16;
        if (cfg_limit > 8'd128) return 128;
        return 32'(cfg_limit);
    endfunction

    function automatic t_burst_desc make_desc(input logic [15:0] a, input logic [7:0] cnt,
                                              input logic idp, input logic [1:0] st,
                                              input logic last);
        t_burst_desc d;
        logic [6:0]  bus;
        bus = cfg_bus_base + (idp ? pawsp_pkg::ID_PAGE_BUS_OFFSET : 7'd0);
        d.addr   = a;
        d.cnt    = cnt;
        d.status = st;
        d.last   = last;
        if (st != pawsp_pkg::ST_OK) begin
            d.bus     = '0;
            d.hi      = '0;
            d.lo      = '0;
            d.send_hi = 1'b0;
        end else begin
            // one-byte mode folds address bits 10..8 into the device address
            if (!cfg_two_byte)
                bus = bus | {4'b0, a[10:8]};
            d.bus     = bus;
            d.hi      = a[15:8];
            d.lo      = a[7:0];
            d.send_hi = cfg_two_byte;
        end
        return d;
    endfunction

    task automatic split_request(input logic [15:0] addr, input logic [9:0] len,
                                 input logic idp);
        int unsigned pg, lim, a, remain, edge_room, cnt, n;
        logic [1:0]  st;
        pg     = legal_page();
        lim    = legal_limit();
        a      = 32'(addr);
        remain = 32'(len);
        if (idp && a + remain > pg)
            st = pawsp_pkg::ST_ID_PAGE;
        else if (a + remain > legal_device())
            st = pawsp_pkg::ST_DEVICE;
        else if (remain > REQ_BYTES_MAX)
            st = pawsp_pkg::ST_LENGTH;
        else
            st = pawsp_pkg::ST_OK;
        if (st != pawsp_pkg::ST_OK || remain == 0) begin
            pending_bursts.push_back(make_desc(addr, 8'd0, idp, st, 1'b1));
        end else begin
            n = 0;
            while (remain > 0 && n < BURSTS_MAX) begin
                edge_room = pg - (a & (pg - 1));
                cnt = lim;
                if (cnt > remain) cnt = remain;
                if (cnt > edge_room) cnt = edge_room;
                remain = remain - cnt;
                pending_bursts.push_back(make_desc(a[15:0], cnt[7:0], idp,
                                                   pawsp_pkg::ST_OK,
                                                   remain == 0 || n == BURSTS_MAX - 1));
                a = (a + cnt) & 16'hFFFF;
                n++;
            end
        end
    endtask

    task automatic send_request(input logic [15:0] addr, input logic [9:0] len,
                                input logic idp);
        int g;
        g = pick_gap();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_start_address <= addr;
        i_byte_length   <= len;
        i_to_id_page    <= idp;
        do @(posedge i_clk); while (!o_in_ready);
        split_request(addr, len, idp);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_bursts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [7:0] pg, input logic [16:0] dev,
                                  input logic [7:0] lim, input logic two,
                                  input logic [6:0] base);
        logic [2:0]  idx [5];
        logic [16:0] val [5];
        idx = '{pawsp_pkg::CFG_PAGE_SIZE, pawsp_pkg::CFG_DEVICE_SIZE,
                pawsp_pkg::CFG_BURST_LIMIT, pawsp_pkg::CFG_TWO_BYTE_ADDR,
                pawsp_pkg::CFG_BUS_BASE_ADDR};
        val = '{{9'd0, pg}, dev, {9'd0, lim}, {16'd0, two}, {10'd0, base}};
        wait_drain();
        repeat (4) @(posedge i_clk);
        for (int i = 0; i < 5; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx[i])
                pawsp_pkg::CFG_PAGE_SIZE:     cfg_page = val[i][7:0];
                pawsp_pkg::CFG_DEVICE_SIZE:   cfg_device = val[i];
                pawsp_pkg::CFG_BURST_LIMIT:   cfg_limit = val[i][7:0];
                pawsp_pkg::CFG_TWO_BYTE_ADDR: cfg_two_byte = val[i][0];
                pawsp_pkg::CFG_BUS_BASE_ADDR: cfg_bus_base = val[i][6:0];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // checks at reset settings: page 64, 32 KiB, 30-byte bursts, two-byte mode
    task automatic test_reset_defaults();
        send_request(16'd0, 10'd0, 1'b0);            // empty request
        send_request(16'd0, 10'd1, 1'b0);
        send_request(16'd0, 10'd64, 1'b0);           // burst limit inside one page
        send_request(16'd60, 10'd10, 1'b0);          // crosses a page boundary
        send_request(16'd32760, 10'd8, 1'b0);        // ends exactly at device end
        send_request(16'd32760, 10'd9, 1'b0);        // one past device end
        send_request(16'd0, 10'd1008, 1'b0);         // longest legal request
        send_request(16'd0, 10'd1009, 1'b0);         // length limit
        send_request(16'd100, 10'd1023, 1'b0);
        send_request(16'd0, 10'd64, 1'b1);           // full id page
        send_request(16'd1, 10'd64, 1'b1);           // crosses id page
        send_request(16'd63, 10'd1, 1'b1);
        send_request(16'hFFFF, 10'd1023, 1'b1);      // id check wins over the others
        send_request(16'hFFFF, 10'd0, 1'b0);
        send_request(16'd0, 10'd0, 1'b1);
        wait_drain();
    endtask

    task automatic test_settings_extremes();
        apply_settings(8'd16, 17'd65536, 8'd16, 1'b0, 7'd0);
        send_request(16'hFFF0, 10'd16, 1'b0);
        send_request(16'h0700, 10'd20, 1'b0);        // folded bits all ones
        send_request(16'hF800, 10'd40, 1'b0);
        send_request(16'hFFFF, 10'd1, 1'b0);
        send_request(16'd0, 10'd1008, 1'b0);         // 63 bursts
        send_request(16'd15, 10'd2, 1'b1);
        send_request(16'd0, 10'd16, 1'b1);
        apply_settings(8'd128, 17'd128, 8'd128, 1'b1, 7'd119);
        send_request(16'd0, 10'd128, 1'b0);
        send_request(16'd0, 10'd128, 1'b1);          // bus address 127
        send_request(16'd1, 10'd128, 1'b0);
        send_request(16'd0, 10'd129, 1'b1);
        send_request(16'd64, 10'd64, 1'b0);
        wait_drain();
    endtask

    task automatic test_odd_settings();
        apply_settings(8'd0, 17'd0, 8'd0, 1'b0, 7'd127);
        send_request(16'd0, 10'd128, 1'b0);
        send_request(16'd120, 10'd9, 1'b0);
        send_request(16'd0, 10'd16, 1'b1);           // id bus address wraps
        apply_settings(8'd255, 17'h1FFFF, 8'd255, 1'b1, 7'd127);
        send_request(16'hFF80, 10'd128, 1'b0);
        send_request(16'd0, 10'd300, 1'b0);
        apply_settings(8'd100, 17'd1000, 8'd17, 1'b0, 7'd5);
        send_request(16'd500, 10'd12, 1'b0);
        send_request(16'd0, 10'd513, 1'b0);
        wait_drain();
    endtask

    task automatic test_random_requests();
        int unsigned pg, dv, maxlen, len, addr;
        logic        idp;
        for (int chunk = 0; chunk < 4; chunk++) begin
            apply_settings(8'd16 << $urandom_range(0, 3), 17'd128 << $urandom_range(0, 9),
                           8'($urandom_range(16, 128)), 1'($urandom_range(0, 1)),
                           7'($urandom_range(0, 127)));
            steady = (chunk == 2);
            pg = legal_page();
            dv = legal_device();
            for (int k = 0; k < 32; k++) begin
                if (k == 16)
                    wait_drain();
                if ($urandom_range(0, 99) < 15) begin
                    send_request(16'($urandom), 10'($urandom), 1'($urandom_range(0, 1)));
                end else begin
                    idp = ($urandom_range(0, 3) == 0);
                    if (idp) begin
                        len  = $urandom_range(0, pg);
                        addr = $urandom_range(0, pg - len);
                    end else begin
                        maxlen = (dv < REQ_BYTES_MAX) ? dv : REQ_BYTES_MAX;
                        if ($urandom_range(0, 99) < 85)
                            len = $urandom_range(0, (maxlen < 96) ? maxlen : 96);
                        else
                            len = $urandom_range(0, maxlen);
                        addr = $urandom_range(0, dv - len);
                    end
                    send_request(addr[15:0], len[9:0], idp);
                end
            end
            wait_drain();
        end
        steady = 1'b0;
    endtask

    always @(posedge i_clk) begin : out_stall
        int g;
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            if (g > 0) begin
                stall_left  <= g - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : burst_check
        t_burst_desc got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_burst_address, o_burst_count, o_bus_address, o_address_high_byte,
                    o_address_low_byte, o_send_high_byte, o_status, o_last_burst};
            if (pending_bursts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected burst: addr %h cnt %0d status %0d",
                             got.addr, got.cnt, got.status);
            end else begin
                want = pending_bursts.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("burst mismatch at %0t", $realtime);
                        $display("  exp addr %h cnt %0d bus %h hi %h lo %h send_hi %b st %0d last %b",
                                 want.addr, want.cnt, want.bus, want.hi, want.lo,
                                 want.send_hi, want.status, want.last);
                        $display("  got addr %h cnt %0d bus %h hi %h lo %h send_hi %b st %0d last %b",
                                 got.addr, got.cnt, got.bus, got.hi, got.lo,
                                 got.send_hi, got.status, got.last);
                    end
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_settings_extremes();
        test_odd_settings();
        test_random_requests();
        wait_drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending_bursts.size() == 0)
            $display("page_aligned_write_splitter test passed");
        else
            $display("page_aligned_write_splitter test failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("page_aligned_write_splitter test failed");
        $finish;
    end

endmodule
